// ===== hdl/rgbpk_pkg.sv =====
// shared types, constants and register codes for the relative rgb to pixel packer
`default_nettype none
package rgbpk_pkg;

	localparam int REQ_W        = 10;
	localparam int LEVEL_W      = 16;
	localparam int FORMAT_W     = 40;
	localparam int PIXEL_W      = 32;
	localparam int SLOT_W       = 10;
	localparam int SEG_WIDTH_W  = 5;
	localparam int MAX_SEGMENTS = 6;
	localparam int FMT_EXT_W    = MAX_SEGMENTS * SLOT_W;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = FORMAT_W;

	localparam int SEGMENTS_PER_CHANNEL_DEF = 4;

	// product of request and level plus rounding half
	localparam int PROD_W = REQ_W + LEVEL_W;
	// product shifted down by three, then divided by 125
	localparam int DIV_IN_W    = PROD_W - 3;
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_PROD_W = DIV_IN_W + RECIP_W;

	localparam logic [REQ_W-1:0]    REQ_FULL  = 10'd1000;
	localparam logic [PROD_W-1:0]   REQ_HALF  = 26'd500;
	localparam logic [RECIP_W-1:0]  RECIP_M   = 26'd34359738;
	localparam logic [DIV_IN_W:0]   DIV_LO    = 24'd125;

	localparam logic [FORMAT_W-1:0] RED_FORMAT_RST   = 40'd357;
	localparam logic [FORMAT_W-1:0] GREEN_FORMAT_RST = 40'd197;
	localparam logic [FORMAT_W-1:0] BLUE_FORMAT_RST  = 40'd5;
	localparam logic [LEVEL_W-1:0]  RED_LEVEL_RST     = 16'd31;
	localparam logic [LEVEL_W-1:0]  GREEN_LEVEL_RST   = 16'd31;
	localparam logic [LEVEL_W-1:0]  BLUE_LEVEL_RST    = 16'd31;
	localparam logic [LEVEL_W-1:0]  ALPHA_LEVEL_RST   = 16'd0;
	localparam logic [LEVEL_W-1:0]  OVERLAY_LEVEL_RST = 16'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RED_FORMAT    = 3'd0,
		CFG_GREEN_FORMAT  = 3'd1,
		CFG_BLUE_FORMAT   = 3'd2,
		CFG_RED_LEVEL     = 3'd3,
		CFG_GREEN_LEVEL   = 3'd4,
		CFG_BLUE_LEVEL    = 3'd5,
		CFG_ALPHA_LEVEL   = 3'd6,
		CFG_OVERLAY_LEVEL = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [FORMAT_W-1:0] red_format;
		logic [FORMAT_W-1:0] green_format;
		logic [FORMAT_W-1:0] blue_format;
		logic [LEVEL_W-1:0]  red_level;
		logic [LEVEL_W-1:0]  green_level;
		logic [LEVEL_W-1:0]  blue_level;
		logic [LEVEL_W-1:0]  alpha_level;
		logic [LEVEL_W-1:0]  overlay_level;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_red;
		logic [REQ_W-1:0] req_green;
		logic [REQ_W-1:0] req_blue;
		logic [REQ_W-1:0] req_alpha;
		logic [REQ_W-1:0] req_overlay;
	} in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] act_red;
		logic [LEVEL_W-1:0] act_green;
		logic [LEVEL_W-1:0] act_blue;
		logic [LEVEL_W-1:0] act_alpha;
		logic [LEVEL_W-1:0] act_overlay;
		logic [PIXEL_W-1:0] pixel_value;
	} out_t;

	// load enables of the scaling stages
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} stage_en_t;

endpackage
`default_nettype wire

// ===== hdl/rgbpk_cfg.sv =====
// configuration register file
`default_nettype none
module rgbpk_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [rgbpk_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [rgbpk_pkg::CFG_DATA_W-1:0]     cfg_data,
	output rgbpk_pkg::cfg_t                           cfg
);

	rgbpk_pkg::cfg_t cfg_q;
	rgbpk_pkg::cfg_idx_t idx;

	assign idx = rgbpk_pkg::cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_format    <= rgbpk_pkg::RED_FORMAT_RST;
			cfg_q.green_format  <= rgbpk_pkg::GREEN_FORMAT_RST;
			cfg_q.blue_format   <= rgbpk_pkg::BLUE_FORMAT_RST;
			cfg_q.red_level     <= rgbpk_pkg::RED_LEVEL_RST;
			cfg_q.green_level   <= rgbpk_pkg::GREEN_LEVEL_RST;
			cfg_q.blue_level    <= rgbpk_pkg::BLUE_LEVEL_RST;
			cfg_q.alpha_level   <= rgbpk_pkg::ALPHA_LEVEL_RST;
			cfg_q.overlay_level <= rgbpk_pkg::OVERLAY_LEVEL_RST;
		end else if (cfg_wr_en) begin
			unique case (idx)
				rgbpk_pkg::CFG_RED_FORMAT:    cfg_q.red_format    <= cfg_data;
				rgbpk_pkg::CFG_GREEN_FORMAT:  cfg_q.green_format  <= cfg_data;
				rgbpk_pkg::CFG_BLUE_FORMAT:   cfg_q.blue_format   <= cfg_data;
				rgbpk_pkg::CFG_RED_LEVEL:     cfg_q.red_level     <= cfg_data[rgbpk_pkg::LEVEL_W-1:0];
				rgbpk_pkg::CFG_GREEN_LEVEL:   cfg_q.green_level   <= cfg_data[rgbpk_pkg::LEVEL_W-1:0];
				rgbpk_pkg::CFG_BLUE_LEVEL:    cfg_q.blue_level    <= cfg_data[rgbpk_pkg::LEVEL_W-1:0];
				rgbpk_pkg::CFG_ALPHA_LEVEL:   cfg_q.alpha_level   <= cfg_data[rgbpk_pkg::LEVEL_W-1:0];
				rgbpk_pkg::CFG_OVERLAY_LEVEL: cfg_q.overlay_level <= cfg_data[rgbpk_pkg::LEVEL_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/rgbpk_scale.sv =====
// one channel: saturate, scale to level and round, divide by 1000 over three stages
`default_nettype none
module rgbpk_scale (
	input  wire logic                              clk,
	input  wire rgbpk_pkg::stage_en_t              en,
	input  wire logic [rgbpk_pkg::REQ_W-1:0]       req,
	input  wire logic [rgbpk_pkg::LEVEL_W-1:0]     level,
	output logic      [rgbpk_pkg::LEVEL_W-1:0]     act
);

	logic [rgbpk_pkg::REQ_W-1:0]        req_sat;
	logic [rgbpk_pkg::PROD_W-1:0]       prod_s2;
	logic [rgbpk_pkg::DIV_IN_W-1:0]     y;
	logic [rgbpk_pkg::RECIP_PROD_W-1:0] recip_prod;
	logic [rgbpk_pkg::DIV_IN_W-1:0]     y_s3;
	logic [rgbpk_pkg::LEVEL_W-1:0]      q0_s3;
	logic [rgbpk_pkg::DIV_IN_W:0]       q0_x125;
	logic [rgbpk_pkg::DIV_IN_W:0]       rem;
	logic [rgbpk_pkg::LEVEL_W-1:0]      act_s4;

	assign req_sat = (req > rgbpk_pkg::REQ_FULL) ? rgbpk_pkg::REQ_FULL : req;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			prod_s2 <= rgbpk_pkg::PROD_W'(req_sat) * rgbpk_pkg::PROD_W'(level)
				+ rgbpk_pkg::REQ_HALF;
		end
	end

	// divide by 8 is a shift, divide by 125 by reciprocal, low by at most one
	assign y = prod_s2[rgbpk_pkg::PROD_W-1:3];
	assign recip_prod = rgbpk_pkg::RECIP_PROD_W'(y) * rgbpk_pkg::RECIP_PROD_W'(rgbpk_pkg::RECIP_M);

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			y_s3  <= y;
			q0_s3 <= recip_prod[rgbpk_pkg::RECIP_SHIFT +: rgbpk_pkg::LEVEL_W];
		end
	end

	// q0 * 125 as 128 - 3
	assign q0_x125 = ((rgbpk_pkg::DIV_IN_W+1)'(q0_s3) << 7)
		- ((rgbpk_pkg::DIV_IN_W+1)'(q0_s3) << 1) - (rgbpk_pkg::DIV_IN_W+1)'(q0_s3);
	assign rem = (rgbpk_pkg::DIV_IN_W+1)'(y_s3) - q0_x125;

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			act_s4 <= (rem >= rgbpk_pkg::DIV_LO) ? q0_s3 + 16'd1 : q0_s3;
		end
	end

	assign act = act_s4;

endmodule
`default_nettype wire

// ===== hdl/rgbpk_scatter.sv =====
// scatters one channel value into pixel bits along its segment list
`default_nettype none
module rgbpk_scatter #(
	parameter int SEGMENTS = rgbpk_pkg::SEGMENTS_PER_CHANNEL_DEF
) (
	input  wire logic [rgbpk_pkg::FORMAT_W-1:0] fmt,
	input  wire logic [rgbpk_pkg::LEVEL_W-1:0]  value,
	output logic      [rgbpk_pkg::PIXEL_W-1:0]  pixel
);

	localparam int WORD_W = rgbpk_pkg::PIXEL_W + rgbpk_pkg::LEVEL_W;

	always_comb begin
		logic [rgbpk_pkg::FMT_EXT_W-1:0] fmt_ext;
		logic [rgbpk_pkg::SLOT_W-1:0]    slot;
		logic [rgbpk_pkg::SEG_WIDTH_W-1:0] w;
		logic [rgbpk_pkg::SEG_WIDTH_W-1:0] pos;
		logic [rgbpk_pkg::LEVEL_W-1:0]   rest;
		logic [rgbpk_pkg::LEVEL_W-1:0]   bits;
		logic [WORD_W-1:0]               word;
		logic                            done;
		// slots above the register read as width zero
		fmt_ext = {(rgbpk_pkg::FMT_EXT_W - rgbpk_pkg::FORMAT_W)'(0), fmt};
		slot = '0;
		w    = '0;
		pos  = '0;
		rest = value;
		bits = '0;
		word = '0;
		done = 1'b0;
		for (int i = 0; i < SEGMENTS; i++) begin
			slot = fmt_ext[i*rgbpk_pkg::SLOT_W +: rgbpk_pkg::SLOT_W];
			w    = slot[rgbpk_pkg::SEG_WIDTH_W-1:0];
			pos  = slot[rgbpk_pkg::SLOT_W-1:rgbpk_pkg::SEG_WIDTH_W];
			if (w == '0) begin
				done = 1'b1;
			end
			if (!done) begin
				if (w >= 5'd16) begin
					bits = rest;
					rest = '0;
				end else begin
					bits = rest & ((16'd1 << w) - 16'd1);
					rest = rest >> w;
				end
				word = word | (WORD_W'(bits) << pos);
			end
		end
		pixel = word[rgbpk_pkg::PIXEL_W-1:0];
	end

endmodule
`default_nettype wire

// ===== hdl/relative_rgb_to_pixel_packer.sv =====
// relative rgb to packed pixel converter top level
// pipeline registers in order: input reg, product, reciprocal divide,
// rounding correction, pixel scatter into output reg
// throughput: one item per cycle; each stage advances when the next has room
// reset: stage valids clear, config registers return to their documented defaults
`default_nettype none
module relative_rgb_to_pixel_packer #(
	parameter int SEGMENTS_PER_CHANNEL = rgbpk_pkg::SEGMENTS_PER_CHANNEL_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire rgbpk_pkg::in_t                    in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output rgbpk_pkg::out_t                        out_data,
	input  wire logic                              cfg_wr_en,
	input  wire logic [rgbpk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rgbpk_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rgbpk_pkg::cfg_t      cfg;
	rgbpk_pkg::stage_en_t en;
	rgbpk_pkg::in_t       in_s1;
	rgbpk_pkg::out_t      out_q;

	logic v_s1, v_s2, v_s3, v_s4, v_out_q;
	logic en_s1, en_out;

	logic [rgbpk_pkg::LEVEL_W-1:0] act_red, act_green, act_blue, act_alpha, act_overlay;
	logic [rgbpk_pkg::PIXEL_W-1:0] pix_red, pix_green, pix_blue;

	rgbpk_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en_out   = !v_out_q || out_ready;
	assign en.en_s4 = !v_s4 || en_out;
	assign en.en_s3 = !v_s3 || en.en_s4;
	assign en.en_s2 = !v_s2 || en.en_s3;
	assign en_s1    = !v_s1 || en.en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en_s1)    v_s1    <= in_valid;
			if (en.en_s2) v_s2    <= v_s1;
			if (en.en_s3) v_s3    <= v_s2;
			if (en.en_s4) v_s4    <= v_s3;
			if (en_out)   v_out_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			in_s1 <= in_data;
		end
	end

	rgbpk_scale u_scale_red (
		.clk (clk), .en (en), .req (in_s1.req_red), .level (cfg.red_level), .act (act_red)
	);
	rgbpk_scale u_scale_green (
		.clk (clk), .en (en), .req (in_s1.req_green), .level (cfg.green_level),
		.act (act_green)
	);
	rgbpk_scale u_scale_blue (
		.clk (clk), .en (en), .req (in_s1.req_blue), .level (cfg.blue_level), .act (act_blue)
	);
	rgbpk_scale u_scale_alpha (
		.clk (clk), .en (en), .req (in_s1.req_alpha), .level (cfg.alpha_level),
		.act (act_alpha)
	);
	rgbpk_scale u_scale_overlay (
		.clk (clk), .en (en), .req (in_s1.req_overlay), .level (cfg.overlay_level),
		.act (act_overlay)
	);

	rgbpk_scatter #(.SEGMENTS(SEGMENTS_PER_CHANNEL)) u_scatter_red (
		.fmt (cfg.red_format), .value (act_red), .pixel (pix_red)
	);
	rgbpk_scatter #(.SEGMENTS(SEGMENTS_PER_CHANNEL)) u_scatter_green (
		.fmt (cfg.green_format), .value (act_green), .pixel (pix_green)
	);
	rgbpk_scatter #(.SEGMENTS(SEGMENTS_PER_CHANNEL)) u_scatter_blue (
		.fmt (cfg.blue_format), .value (act_blue), .pixel (pix_blue)
	);

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q.act_red     <= act_red;
			out_q.act_green   <= act_green;
			out_q.act_blue    <= act_blue;
			out_q.act_alpha   <= act_alpha;
			out_q.act_overlay <= act_overlay;
			out_q.pixel_value <= pix_red | pix_green | pix_blue;
		end
	end

	assign out_valid = v_out_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
